[rtl/core/uksort_pkg.sv]
// Shared constants and types for the unsigned key sorter.
`timescale 1ns / 1ps
package uksort_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_BITS = 32;
  localparam int ADDR_W   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  typedef struct packed {
    logic [31:0] key_value;
    logic        last_key;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sorted_key;
    logic        end_of_run;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic accept_key;
    logic set_drop;
    logic rd_prev;
    logic shift;
    logic place;
    logic rd_out;
    logic next_out;
    logic clear;
  } uks_cmd_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic greater;
    logic out_last;
  } uks_status_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_COMP   = 6'b000100,
    S_PLACE  = 6'b001000,
    S_OUT_RD = 6'b010000,
    S_OUT    = 6'b100000
  } uks_state_t;

endpackage

[rtl/core/uksort_ctrl.sv]
// Controller state machine for the unsigned key sorter.
`timescale 1ns / 1ps
module uksort_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  uksort_pkg::uks_status_t st,
  output uksort_pkg::uks_cmd_t    cmd
);
  import uksort_pkg::*;

  uks_state_t state, state_next;
  logic       last_pend, last_pend_next;
  logic       in_xfer, out_xfer;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  always_comb begin
    state_next     = state;
    last_pend_next = last_pend;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (st.full) begin
            cmd.set_drop = 1'b1;
            if (in_last) begin
              state_next = S_OUT_RD;
            end
          end else begin
            cmd.accept_key = 1'b1;
            last_pend_next = in_last;
            state_next     = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (st.idx_zero) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_COMP;
        end
      end
      S_COMP: begin
        if (st.greater) begin
          cmd.shift  = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = last_pend ? S_OUT_RD : S_IDLE;
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          if (st.out_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.next_out = 1'b1;
            state_next   = S_OUT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_pend <= 1'b0;
    end else begin
      state     <= state_next;
      last_pend <= last_pend_next;
    end
  end

endmodule

[rtl/core/uksort_datapath.sv]
// Key memory, insertion pointers and output formatting for the key sorter.
`timescale 1ns / 1ps
module uksort_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  uksort_pkg::in_item_t    in_data,
  input  uksort_pkg::uks_cmd_t    cmd,
  output uksort_pkg::uks_status_t st,
  output uksort_pkg::out_item_t   out_data
);
  import uksort_pkg::*;

  logic [KEY_BITS-1:0] mem [MAX_KEYS];
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]   idx;
  logic [ADDR_W-1:0]   oidx;
  logic [CNT_W-1:0]    count;
  logic                dropped;
  logic [ADDR_W-1:0]   rd_addr;

  assign rd_addr     = cmd.rd_out ? oidx : idx - ADDR_W'(1);
  assign st.full     = (count == CNT_W'(MAX_KEYS));
  assign st.idx_zero = (idx == '0);
  assign st.greater  = (rd_data > key);
  assign st.out_last = ((CNT_W'(oidx) + CNT_W'(1)) == count);

  assign out_data.sorted_key = 32'(rd_data);
  assign out_data.end_of_run = st.out_last;
  assign out_data.overflow   = dropped;

  always_ff @(posedge clk) begin
    if (cmd.rd_prev || cmd.rd_out) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.shift) begin
      mem[idx] <= rd_data;
    end else if (cmd.place) begin
      mem[idx] <= key;
    end
    if (cmd.accept_key) begin
      key <= in_data.key_value[KEY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      oidx    <= '0;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.accept_key) begin
        idx <= count[ADDR_W-1:0];
      end else if (cmd.shift) begin
        idx <= idx - ADDR_W'(1);
      end
      if (cmd.place) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.set_drop) begin
        dropped <= 1'b1;
      end
      if (cmd.next_out) begin
        oidx <= oidx + ADDR_W'(1);
      end
      if (cmd.clear) begin
        count   <= '0;
        dropped <= 1'b0;
        oidx    <= '0;
      end
    end
  end

endmodule

[rtl/core/unsigned_key_sorter_unit.sv]
// Top level of the unsigned key sorter.
// Keys are collected into a 64-entry memory, each inserted into sorted position as it
// arrives by a read, compare and write loop on the single key memory that moves every
// larger stored key up one place; the next key is not taken until that insertion is done.
// A key that arrives while the memory is full is dropped. After the key marked last, the
// batch is delivered in ascending order; no key is taken while results are being
// delivered. Keys beyond 64 are dropped and flag overflow on every result of that
// batch.
`timescale 1ns / 1ps
module unsigned_key_sorter_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  uksort_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output uksort_pkg::out_item_t out_data
);
  import uksort_pkg::*;

  uks_cmd_t    cmd;
  uks_status_t st;

  uksort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_key),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  uksort_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

[rtl/core/uksort_checker.sv]
// Port-level checks for the unsigned key sorter, bound to the top level.
`timescale 1ns / 1ps
module uksort_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input uksort_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input uksort_pkg::out_item_t out_data
);
  import uksort_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting for transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken during result delivery");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.end_of_run |=> !out_valid && in_ready)
    else $error("delivery continued after final transfer");

endmodule

bind unsigned_key_sorter_unit uksort_checker u_uksort_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
